FILE: src/nlt_pkg.sv
// ----------------------------------------------------------------------------
// nlt_pkg
// types and constants shared by the neighbor liveness table
// ----------------------------------------------------------------------------
`default_nettype none
package nlt_pkg;
    localparam int unsigned MaxNeighborsDefault = 32;
    localparam int unsigned WarnReset   = 360000;
    localparam int unsigned DetectReset = 540000;

    typedef enum logic [1:0] {
        FUNC_HEARD = 2'd0,
        FUNC_SCAN  = 2'd1,
        FUNC_QADDR = 2'd2,
        FUNC_QIDX  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_WARN   = 2'd0,
        CFG_DETECT = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_HOLD = 2'd2
    } t_state;

    // token that walks down the cell chain
    typedef struct packed {
        logic        vld;
        t_func       func;
        logic [15:0] addr;
        logic [4:0]  idx;
        logic [31:0] now;
        logic        hit;
        logic        failed;
        logic [1:0]  missed;
        logic [31:0] silence;
        logic [15:0] addr_out;
        logic [5:0]  count;
        logic        new_entry;
    } t_token;
endpackage
`default_nettype wire

FILE: src/nlt_in_if.sv
// ----------------------------------------------------------------------------
// nlt_in_if
// request channel of the neighbor liveness table
// ----------------------------------------------------------------------------
`default_nettype none
interface nlt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] neighbor_address;
    logic [4:0]  entry_index;
    logic [31:0] now_ms;
    modport source (output valid, func, neighbor_address, entry_index, now_ms, input ready);
    modport sink   (input valid, func, neighbor_address, entry_index, now_ms, output ready);
endinterface
`default_nettype wire

FILE: src/nlt_out_if.sv
// ----------------------------------------------------------------------------
// nlt_out_if
// result channel of the neighbor liveness table
// ----------------------------------------------------------------------------
`default_nettype none
interface nlt_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic        failed;
    logic [1:0]  missed_count;
    logic [31:0] silence_ms;
    logic [15:0] address_out;
    logic [5:0]  newly_failed_count;
    logic        new_entry;
    logic        table_full;
    modport source (output valid, found, failed, missed_count, silence_ms, address_out,
                    newly_failed_count, new_entry, table_full, input ready);
    modport sink   (input valid, found, failed, missed_count, silence_ms, address_out,
                    newly_failed_count, new_entry, table_full, output ready);
endinterface
`default_nettype wire

FILE: src/neighbor_liveness_table.sv
// flow: an accepted request is registered in r_launch, walks the cell chain one
//   cell per cycle into r_fin and waits there while the output stalls; requests
//   are taken only in idle, once the last result is in the output register
// reset: synchronous active low; clears the entry count, control and valids,
//   thresholds return to 360000 / 540000 ms; entry contents are not cleared
// ----------------------------------------------------------------------------
// neighbor_liveness_table
// heartbeat timeout failure detector built as a chain of entry cells
// ----------------------------------------------------------------------------
`default_nettype none
module neighbor_liveness_table #(
    parameter int unsigned MAX_NEIGHBORS = nlt_pkg::MaxNeighborsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    nlt_in_if.sink           i_in,
    nlt_out_if.source        o_out
);
    localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);

    nlt_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_used;
    logic [31:0]     r_warn, r_detect;
    nlt_pkg::t_token r_launch, n_launch, r_fin;
    nlt_pkg::t_token tok [MAX_NEIGHBORS+1];
    logic            accept, out_free;

    assign i_in.ready = r_state == nlt_pkg::ST_IDLE;
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !o_out.valid || o_out.ready;
    assign tok[0]     = r_launch;

    // token built from the request beat, result fields start cleared
    always_comb begin
        n_launch      = '0;
        n_launch.vld  = accept;
        n_launch.func = nlt_pkg::t_func'(i_in.func);
        n_launch.addr = i_in.neighbor_address;
        n_launch.idx  = i_in.entry_index;
        n_launch.now  = i_in.now_ms;
    end

    // token enters cell 0 in the cycle after the request beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= '0;
        end else begin
            r_launch <= n_launch;
        end
    end

    for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
        nlt_cell #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_used  (r_used),
            .i_warn  (r_warn),
            .i_detect(r_detect),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    // controller: idle, token walking, result waiting for the output register
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nlt_pkg::ST_IDLE: if (accept) n_state = nlt_pkg::ST_RUN;
            nlt_pkg::ST_RUN:  if (tok[MAX_NEIGHBORS].vld) n_state = nlt_pkg::ST_HOLD;
            nlt_pkg::ST_HOLD: if (out_free) n_state = nlt_pkg::ST_IDLE;
            default:          n_state = nlt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nlt_pkg::ST_IDLE;
            r_used      <= '0;
            o_out.valid <= 1'b0;
            r_warn      <= 32'(nlt_pkg::WarnReset);
            r_detect    <= 32'(nlt_pkg::DetectReset);
        end else begin
            r_state <= n_state;
            if (tok[MAX_NEIGHBORS].vld) begin
                r_fin <= tok[MAX_NEIGHBORS];
                // a new entry landed in the tail cell
                if (tok[MAX_NEIGHBORS].new_entry) r_used <= r_used + CW'(1);
            end
            if (r_state == nlt_pkg::ST_HOLD && out_free) begin
                o_out.valid              <= 1'b1;
                o_out.found              <= r_fin.hit && (r_fin.func == nlt_pkg::FUNC_HEARD ||
                                                          r_fin.func == nlt_pkg::FUNC_QADDR);
                o_out.failed             <= r_fin.failed;
                o_out.missed_count       <= r_fin.missed;
                o_out.silence_ms         <= r_fin.silence;
                o_out.address_out        <= r_fin.addr_out;
                o_out.newly_failed_count <= r_fin.count;
                o_out.new_entry          <= r_fin.new_entry;
                o_out.table_full         <= r_fin.func == nlt_pkg::FUNC_HEARD &&
                                            !r_fin.hit && !r_fin.new_entry;
            end else if (o_out.valid && o_out.ready) begin
                o_out.valid <= 1'b0;
            end
            // threshold writes keep warning strictly below detection
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nlt_pkg::CFG_WARN:   if (i_cfg_data < r_detect) r_warn <= i_cfg_data;
                    nlt_pkg::CFG_DETECT: if (i_cfg_data > r_warn) r_detect <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/nlt_cell.sv
// ----------------------------------------------------------------------------
// nlt_cell
// one table entry plus one stage of the token chain
// ----------------------------------------------------------------------------
`default_nettype none
module nlt_cell #(
    parameter int unsigned MAX_NEIGHBORS = nlt_pkg::MaxNeighborsDefault,
    parameter int unsigned IDX = 0,
    localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [CW-1:0]   i_used,
    input  wire logic [31:0]     i_warn,
    input  wire logic [31:0]     i_detect,
    input  wire nlt_pkg::t_token i_tok,
    output nlt_pkg::t_token      o_tok
);
    localparam logic [CW-1:0] MyIdx = CW'(IDX);

    logic [15:0] r_addr, n_addr;
    logic [31:0] r_last, n_last;
    logic [1:0]  r_missed, n_missed;
    logic        r_failed, n_failed;
    nlt_pkg::t_token n_tok;
    logic        in_use, tail;
    logic [31:0] silence;

    assign in_use  = MyIdx < i_used;
    assign tail    = MyIdx == i_used;
    assign silence = i_tok.now - r_last;

    always_comb begin
        n_tok    = i_tok;
        n_addr   = r_addr;
        n_last   = r_last;
        n_missed = r_missed;
        n_failed = r_failed;
        if (i_tok.vld) begin
            unique case (i_tok.func)
                nlt_pkg::FUNC_HEARD: begin
                    if (in_use && !i_tok.hit && r_addr == i_tok.addr) begin
                        n_last    = i_tok.now;
                        n_missed  = 2'd0;
                        n_failed  = 1'b0;
                        n_tok.hit = 1'b1;
                    end else if (tail && !i_tok.hit) begin
                        n_addr          = i_tok.addr;
                        n_last          = i_tok.now;
                        n_missed        = 2'd0;
                        n_failed        = 1'b0;
                        n_tok.new_entry = 1'b1;
                    end
                end
                nlt_pkg::FUNC_SCAN: begin
                    if (in_use && r_addr != 16'd0 && r_last != 32'd0) begin
                        if (silence > i_warn && silence < i_detect && r_missed == 2'd0)
                            n_missed = 2'd1;
                        if (silence > i_detect && !r_failed) begin
                            n_missed    = 2'd2;
                            n_failed    = 1'b1;
                            n_tok.count = i_tok.count + 6'd1;
                        end
                    end
                end
                nlt_pkg::FUNC_QADDR: begin
                    if (in_use && !i_tok.hit && r_addr == i_tok.addr) begin
                        n_tok.hit     = 1'b1;
                        n_tok.failed  = r_failed;
                        n_tok.missed  = r_missed;
                        n_tok.silence = silence;
                    end
                end
                nlt_pkg::FUNC_QIDX: begin
                    if (in_use && 32'(IDX) == 32'(i_tok.idx))
                        n_tok.addr_out = r_addr;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_last   <= n_last;
        r_missed <= n_missed;
        r_failed <= n_failed;
        if (!i_rst_n) begin
            o_tok <= '0;
        end else begin
            o_tok <= n_tok;
        end
    end
endmodule
`default_nettype wire
